### src/uqst_pkg.sv
package uqst_pkg;

  localparam int MAX_INPUT_DEF = 8192;
  localparam int CFG_W         = 14;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [4:0] HEX_BAD  = 5'd16;

  typedef enum logic [1:0] {
    KIND_KEY      = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_RESTART  = 2'd2,
    KIND_PAIR_END = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       keep;
    logic       err;
    logic       done;
  } tok_t;

  // digit value 0..15, HEX_BAD for anything else
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    begin
      if (c >= 8'h30 && c <= 8'h39) begin
        v = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        v = {1'b0, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        v = {1'b0, 4'(c - 8'h37)};
      end else begin
        v = HEX_BAD;
      end
      return v;
    end
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // two-character base-16 conversion with optional leading space or sign
  function automatic logic [7:0] decode_pair(input logic [7:0] c1, input logic [7:0] c2);
    logic [4:0] h1;
    logic [4:0] h2;
    logic [7:0] r;
    begin
      h1 = hex_val(c1);
      h2 = hex_val(c2);
      if (is_space(c1)) begin
        r = h2[4] ? 8'h00 : {4'h0, h2[3:0]};
      end else if (c1 == CH_PLUS || c1 == CH_MINUS) begin
        if (h2[4]) begin
          r = 8'h00;
        end else if (c1 == CH_MINUS) begin
          r = 8'h00 - {4'h0, h2[3:0]};
        end else begin
          r = {4'h0, h2[3:0]};
        end
      end else if (h1[4]) begin
        r = 8'h00;
      end else if (h2[4]) begin
        r = {4'h0, h1[3:0]};
      end else begin
        r = {h1[3:0], h2[3:0]};
      end
      return r;
    end
  endfunction

endpackage

### src/uqst_parse.sv
module uqst_parse #(
  parameter int CNT_W = uqst_pkg::CFG_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                in_end,
  input  logic [CNT_W-1:0]    max_chars,
  output logic                res_valid,
  output uqst_pkg::tok_t      res
);

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_FIRST,
    ESC_SECOND
  } esc_t;

  esc_t             esc_r,       esc_nxt;
  logic             in_key_r,    in_key_nxt;
  logic             key_seen_r,  key_seen_nxt;
  logic [7:0]       first_r,     first_nxt;
  logic [CNT_W-1:0] cnt_r,       cnt_nxt;

  logic [7:0]       byte_c;
  logic             room_esc;

  assign byte_c   = (in_byte == uqst_pkg::CH_PLUS) ? uqst_pkg::CH_SPACE : in_byte;
  // after counting this percent, two more bytes must still fit
  assign room_esc = ({2'b00, cnt_r} + (CNT_W+2)'(3)) <= {2'b00, max_chars};

  always_comb begin
    esc_nxt      = esc_r;
    in_key_nxt   = in_key_r;
    key_seen_nxt = key_seen_r;
    first_nxt    = first_r;
    cnt_nxt      = cnt_r;
    res_valid    = 1'b0;
    res          = '{kind: uqst_pkg::KIND_KEY, data: 8'h00, keep: 1'b0,
                     err: 1'b0, done: 1'b0};
    if (accept) begin
      if (in_end) begin
        res_valid    = 1'b1;
        res.kind     = uqst_pkg::KIND_PAIR_END;
        res.err      = (esc_r != ESC_IDLE);
        res.keep     = (esc_r == ESC_IDLE) && key_seen_r;
        res.done     = 1'b1;
        esc_nxt      = ESC_IDLE;
        in_key_nxt   = 1'b1;
        key_seen_nxt = 1'b0;
        first_nxt    = 8'h00;
        cnt_nxt      = '0;
      end else if (esc_r == ESC_FIRST) begin
        first_nxt = in_byte;
        esc_nxt   = ESC_SECOND;
        cnt_nxt   = cnt_r + CNT_W'(1);
      end else if (esc_r == ESC_SECOND) begin
        esc_nxt   = ESC_IDLE;
        cnt_nxt   = cnt_r + CNT_W'(1);
        res_valid = 1'b1;
        res.data  = uqst_pkg::decode_pair(first_r, in_byte);
        res.kind  = in_key_r ? uqst_pkg::KIND_KEY : uqst_pkg::KIND_VALUE;
        if (in_key_r) begin
          key_seen_nxt = 1'b1;
        end
      end else if (cnt_r < max_chars) begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (byte_c == uqst_pkg::CH_AMP) begin
          res_valid    = 1'b1;
          res.kind     = uqst_pkg::KIND_PAIR_END;
          res.keep     = key_seen_r;
          in_key_nxt   = 1'b1;
          key_seen_nxt = 1'b0;
        end else if (byte_c == uqst_pkg::CH_EQ) begin
          res_valid  = 1'b1;
          res.kind   = uqst_pkg::KIND_RESTART;
          in_key_nxt = 1'b0;
        end else if (byte_c == uqst_pkg::CH_PCT && room_esc) begin
          esc_nxt = ESC_FIRST;
        end else begin
          res_valid = 1'b1;
          res.data  = byte_c;
          res.kind  = in_key_r ? uqst_pkg::KIND_KEY : uqst_pkg::KIND_VALUE;
          if (in_key_r) begin
            key_seen_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r      <= ESC_IDLE;
      in_key_r   <= 1'b1;
      key_seen_r <= 1'b0;
      first_r    <= 8'h00;
      cnt_r      <= '0;
    end else begin
      esc_r      <= esc_nxt;
      in_key_r   <= in_key_nxt;
      key_seen_r <= key_seen_nxt;
      first_r    <= first_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule

### src/url_query_string_tokenizer_core.sv
// url query string tokenizer
// input channel: one raw byte per transfer (in_byte), or an end marker
//   (in_end_marker) that closes the stream; in_valid / in_stall handshake
// output channel: at most one token per input transfer, out_valid / out_stall;
//   kind is key byte, value byte, value restart or pair end
// config channel: cfg_max_chars sets how many stream bytes are processed,
//   values above MAX_INPUT saturate; cfg_ready is always high, write only
//   while the stream is idle
// throughput: one input transfer per cycle while in_stall is low; the stream state
//   update and the token decode sit between the input and the output register
// output: a token is registered in the output register, or parked in the skid
// stall: a skid register catches one token while the receiver stalls; in_stall
//   rises only when that skid is full, and drops once the receiver takes one
// reset: synchronous, active low; clears stream state and output valids,
//   and max_chars returns to MAX_INPUT; no clearing pass is needed
module url_query_string_tokenizer_core #(
  parameter int MAX_INPUT = uqst_pkg::MAX_INPUT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // byte stream in
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_byte,
  input  logic                       in_end_marker,
  // tokens out
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_token_kind,
  output logic [7:0]                 out_byte,
  output logic                       out_keep_pair,
  output logic                       out_parse_error,
  output logic                       out_stream_done,
  // config write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [uqst_pkg::CFG_W-1:0] cfg_max_chars
);

  // counter must hold max_chars itself
  localparam int CNT_W = $clog2(MAX_INPUT + 1);
  localparam int CMP_W = (CNT_W > uqst_pkg::CFG_W) ? CNT_W : uqst_pkg::CFG_W;

  logic [CNT_W-1:0] max_chars_r;
  logic [CMP_W-1:0] cfg_ext;

  logic             in_acc;
  logic             out_take;
  logic             res_valid;
  uqst_pkg::tok_t   res;

  // output register and skid register
  logic             out_valid_r,  out_valid_nxt;
  uqst_pkg::tok_t   out_tok_r,    out_tok_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  uqst_pkg::tok_t   skid_tok_r,   skid_tok_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_ext   = CMP_W'(cfg_max_chars);

  // config register, saturating at MAX_INPUT
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= CNT_W'(MAX_INPUT);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_ext > CMP_W'(MAX_INPUT)) begin
        max_chars_r <= CNT_W'(MAX_INPUT);
      end else begin
        max_chars_r <= cfg_ext[CNT_W-1:0];
      end
    end
  end

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  uqst_parse #(
    .CNT_W (CNT_W)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .in_byte   (in_byte),
    .in_end    (in_end_marker),
    .max_chars (max_chars_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // steer a fresh token into the output register when it is free or being
  // taken, else park it in the skid; a parked token moves up on a take
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_tok_nxt    = out_tok_r;
    skid_valid_nxt = skid_valid_r;
    skid_tok_nxt   = skid_tok_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_tok_nxt    = skid_tok_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_take) begin
        out_tok_nxt   = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_tok_nxt   = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    out_tok_r  <= out_tok_nxt;
    skid_tok_r <= skid_tok_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_token_kind  = out_tok_r.kind;
  assign out_byte        = out_tok_r.data;
  assign out_keep_pair   = out_tok_r.keep;
  assign out_parse_error = out_tok_r.err;
  assign out_stream_done = out_tok_r.done;

endmodule

### src/uqst_checker.sv
module uqst_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 out_token_kind,
  input logic [7:0]                 out_byte,
  input logic                       out_keep_pair,
  input logic                       out_parse_error,
  input logic                       out_stream_done
);

  // a stalled token stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_kind)
      && $stable(out_byte) && $stable(out_keep_pair))
    else $error("stalled token changed");

  // stream end is always reported as a pair end
  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_done |->
      out_token_kind == uqst_pkg::KIND_PAIR_END)
    else $error("stream end without pair end");

  // an error drops the pair and only comes with the stream end
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parse_error |-> out_stream_done && !out_keep_pair)
    else $error("parse error on wrong token");

  // input backpressure only follows a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && $past(rst_n) && in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // no backpressure and no output token right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_stall && !out_valid)
    else $error("not idle after reset");

endmodule

bind url_query_string_tokenizer_core uqst_checker u_uqst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_token_kind  (out_token_kind),
  .out_byte        (out_byte),
  .out_keep_pair   (out_keep_pair),
  .out_parse_error (out_parse_error),
  .out_stream_done (out_stream_done)
);
